/* design/dsw_pkg.sv */
// Shared types and constants for the damped string wave stepper.
package dsw_pkg;

    // Transaction kinds
    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 16;
    localparam logic [1:0]  CFG_WAVE_SPEED = 2'd0;
    localparam logic [1:0]  CFG_DAMPING    = 2'd1;
    localparam logic [1:0]  CFG_TIME_STEP  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] WAVE_SPEED_RST = 16'd256;
    localparam logic [15:0] DAMPING_RST    = 16'd0;
    localparam logic [15:0] TIME_STEP_RST  = 16'd4096;

    // Displacement format and saturation limits (Q3.12)
    localparam int                 DISP_W  = 16;
    localparam logic signed [15:0] Q12_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q12_MIN = -16'sh8000;

    // Datapath widths
    localparam int MUL_W   = 33;   // shared multiplier operand width
    localparam int PROD_W  = 66;   // shared multiplier product width
    localparam int ACC_W   = 60;   // Q.36 accumulator
    localparam int FRAC_SH = 24;   // Q.36 to Q.12 shift
    localparam int CFL_W   = 40;   // (c*dt)^2, unsigned Q16.24
    localparam int GD_W    = 32;   // damping*dt, unsigned Q8.24
    localparam int LAP_W   = 18;
    localparam int VEL_W   = 17;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_COEF_CD,
        ST_COEF_CFL,
        ST_COEF_GD,
        ST_COEF_SAVE,
        ST_PRIME,
        ST_FETCH,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_GD,
        ST_SUB_GD,
        ST_WRITE
    } t_state;

endpackage

/* design/dsw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/damped_string_wave_step.sv */
// Damped 1-D wave equation stepper over a bank of strings held in two RAMs.
//
// The block keeps current and previous displacement (signed Q3.12) for
// STRING_COUNT strings of POINT_COUNT points. A set writes one current point,
// a read returns one current point, and an advance runs one leapfrog step of
// the damped wave equation over every string with pinned ends and Q3.12
// saturation. After reset a clearing pass zeroes both RAMs, during which no
// transaction is accepted; configuration writes are taken at any time. A set
// or read goes through the result state into the output register. An advance
// first derives the coefficients on the shared multiplier (states COEF_CD,
// COEF_CFL, COEF_GD and COEF_SAVE), then each point needs a RAM fetch, three
// passes through the single 33x33 multiplier with an accumulate after each,
// and a round, saturate and write-back step; each string first primes its
// sliding window, and a final step hands the result over. One transaction
// is in work at a time; the input channel stalls until its result is in the
// output register, and a stalled output register holds the block in that step.
module damped_string_wave_step #(
    parameter int STRING_COUNT = 8,
    parameter int POINT_COUNT  = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [2:0]                       i_string_index,
    input  logic [5:0]                       i_point_index,
    input  logic signed [15:0]               i_new_value,
    // Output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [15:0]               o_read_value,
    output logic                             o_saturated,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [dsw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import dsw_pkg::*;

    localparam int CELL_COUNT = STRING_COUNT * POINT_COUNT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int PW         = $clog2(POINT_COUNT);

    // Sequencer and control registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [PW-1:0]       r_pt, n_pt;
    logic                r_is_read, n_is_read;
    logic                r_sat, n_sat;
    logic                r_out_valid, n_out_valid;

    // Configuration registers
    logic [15:0]         r_wave_speed, n_wave_speed;
    logic [15:0]         r_damping, n_damping;
    logic [15:0]         r_time_step, n_time_step;

    // Datapath registers
    logic [CFL_W-1:0]          r_cfl, n_cfl;
    logic [GD_W-1:0]           r_gd, n_gd;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [LAP_W-1:0]   r_lap, n_lap;
    logic signed [VEL_W-1:0]   r_vel, n_vel;
    logic signed [DISP_W-1:0]  r_w_left, n_w_left;
    logic signed [DISP_W-1:0]  r_w_cur, n_w_cur;
    logic signed [DISP_W-1:0]  r_w_next, n_w_next;
    logic signed [DISP_W-1:0]  r_read_value, n_read_value;
    logic                      r_saturated, n_saturated;

    // Shared multiplier operands
    logic signed [MUL_W-1:0]   mul_a, mul_b;

    // RAM ports
    logic                cur_we, prev_we;
    logic [AW-1:0]       cur_waddr, cur_raddr, prev_raddr;
    logic [DISP_W-1:0]   cur_wdata, prev_wdata;
    logic [DISP_W-1:0]   cur_rdata, prev_rdata;

    // Derived combinational terms
    logic                      in_accept;
    logic                      out_free;
    logic                      addr_ok;
    logic [AW-1:0]             item_addr;
    logic                      endpoint;
    logic                      last_cell;
    logic                      read_ahead;
    logic signed [DISP_W-1:0]  q_cur, q_prev;
    logic signed [LAP_W-1:0]   load_lap;
    logic signed [VEL_W-1:0]   load_vel;
    logic signed [LAP_W-1:0]   load_base;
    logic [63:0]               cfl_sum;
    logic signed [ACC_W-1:0]   rnd_sum;
    logic signed [ACC_W-FRAC_SH-1:0] rnd_q;
    logic                      clip_hi, clip_lo;
    logic signed [DISP_W-1:0]  sat_val;

    // Current and previous displacement stores
    dsw_ram #(.WIDTH(DISP_W), .DEPTH(CELL_COUNT)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    dsw_ram #(.WIDTH(DISP_W), .DEPTH(CELL_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (r_addr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    // Handshake and addressing
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign addr_ok    = (32'(i_string_index) < STRING_COUNT) &&
                        (32'(i_point_index) < POINT_COUNT);
    assign item_addr  = AW'(32'(i_string_index) * POINT_COUNT + 32'(i_point_index));
    assign endpoint   = (r_pt == '0) || (r_pt == PW'(POINT_COUNT - 1));
    assign last_cell  = (r_addr == AW'(CELL_COUNT - 1));
    assign read_ahead = ((PW+1)'(r_pt) + (PW+1)'(2)) < (PW+1)'(POINT_COUNT);

    // Stencil terms from the window and the freshly read RAM words
    assign q_cur     = $signed(cur_rdata);
    assign q_prev    = $signed(prev_rdata);
    assign load_lap  = LAP_W'(q_cur) + LAP_W'(r_w_left) - (LAP_W'(r_w_cur) <<< 1);
    assign load_vel  = VEL_W'(r_w_cur) - VEL_W'(q_prev);
    assign load_base = (LAP_W'(r_w_cur) <<< 1) - LAP_W'(q_prev);

    // Coefficient rounding: (cd*cd + 2^23) >> 24
    assign cfl_sum = r_prod[63:0] + (64'd1 << (FRAC_SH - 1));

    // Round Q.36 to Q.12 with ties up, then clip to Q3.12
    assign rnd_sum = r_acc + (ACC_W'(1) <<< (FRAC_SH - 1));
    assign rnd_q   = rnd_sum[ACC_W-1:FRAC_SH];
    assign clip_hi = rnd_q > Q12_MAX;
    assign clip_lo = rnd_q < Q12_MIN;
    assign sat_val = clip_hi ? Q12_MAX : (clip_lo ? Q12_MIN : rnd_q[DISP_W-1:0]);

    // Shared multiplier
    assign n_prod = mul_a * mul_b;

    // Sequencer: next state, datapath and RAM control
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_pt         = r_pt;
        n_is_read    = r_is_read;
        n_sat        = r_sat;
        n_out_valid  = r_out_valid && i_out_stall;
        n_read_value = r_read_value;
        n_saturated  = r_saturated;
        n_cfl        = r_cfl;
        n_gd         = r_gd;
        n_acc        = r_acc;
        n_lap        = r_lap;
        n_vel        = r_vel;
        n_w_left     = r_w_left;
        n_w_cur      = r_w_cur;
        n_w_next     = r_w_next;
        mul_a        = '0;
        mul_b        = '0;
        cur_we       = 1'b0;
        cur_waddr    = r_addr;
        cur_wdata    = '0;
        cur_raddr    = r_addr;
        prev_we      = 1'b0;
        prev_wdata   = '0;
        prev_raddr   = r_addr;

        case (r_state)
            // Zero both stores, one entry a cycle
            ST_CLEAR: begin
                cur_we  = 1'b1;
                prev_we = 1'b1;
                if (last_cell) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end

            // Take a transaction and dispatch on its kind
            ST_IDLE: begin
                if (in_accept) begin
                    n_is_read = 1'b0;
                    n_sat     = 1'b0;
                    n_state   = ST_EMIT;
                    case (i_kind)
                        KIND_SET: begin
                            cur_we    = addr_ok;
                            cur_waddr = item_addr;
                            cur_wdata = i_new_value;
                        end
                        KIND_READ: begin
                            cur_raddr = item_addr;
                            n_addr    = item_addr;
                            n_is_read = addr_ok;
                        end
                        KIND_ADVANCE: begin
                            n_state = ST_COEF_CD;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end

            // Hand the result to the output register once it is free
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_read_value = r_is_read ? q_cur : '0;
                    n_saturated  = r_sat;
                    n_addr       = '0;
                    n_state      = ST_IDLE;
                end
            end

            // c*dt
            ST_COEF_CD: begin
                mul_a   = MUL_W'(r_wave_speed);
                mul_b   = MUL_W'(r_time_step);
                n_state = ST_COEF_CFL;
            end

            // (c*dt)^2
            ST_COEF_CFL: begin
                mul_a   = MUL_W'(r_prod[31:0]);
                mul_b   = MUL_W'(r_prod[31:0]);
                n_state = ST_COEF_GD;
            end

            // Round the Courant term, then damping*dt
            ST_COEF_GD: begin
                n_cfl   = cfl_sum[FRAC_SH+CFL_W-1:FRAC_SH];
                mul_a   = MUL_W'(r_damping);
                mul_b   = MUL_W'(r_time_step);
                n_state = ST_COEF_SAVE;
            end

            ST_COEF_SAVE: begin
                n_gd    = r_prod[GD_W-1:0];
                n_addr  = '0;
                n_pt    = '0;
                n_state = ST_PRIME;
            end

            // Fetch the first point of a string
            ST_PRIME: begin
                cur_raddr = r_addr;
                n_state   = ST_FETCH;
            end

            // Hold the first point, fetch its right neighbor and old value
            ST_FETCH: begin
                n_w_cur    = q_cur;
                cur_raddr  = r_addr + AW'(1);
                prev_raddr = r_addr;
                n_state    = ST_LOAD;
            end

            // Form stencil terms from old values only
            ST_LOAD: begin
                n_w_next = q_cur;
                n_lap    = load_lap;
                n_vel    = load_vel;
                n_acc    = ACC_W'(load_base) <<< FRAC_SH;
                n_state  = ST_MUL_LO;
            end

            ST_MUL_LO: begin
                mul_a   = MUL_W'(r_cfl[FRAC_SH-1:0]);
                mul_b   = MUL_W'(r_lap);
                n_state = ST_MUL_HI;
            end

            ST_MUL_HI: begin
                n_acc   = r_acc + r_prod[ACC_W-1:0];
                mul_a   = MUL_W'(r_cfl[CFL_W-1:FRAC_SH]);
                mul_b   = MUL_W'(r_lap);
                n_state = ST_MUL_GD;
            end

            ST_MUL_GD: begin
                n_acc   = r_acc + {r_prod[ACC_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
                mul_a   = MUL_W'(r_gd);
                mul_b   = MUL_W'(r_vel);
                n_state = ST_SUB_GD;
            end

            ST_SUB_GD: begin
                n_acc   = r_acc - r_prod[ACC_W-1:0];
                n_state = ST_WRITE;
            end

            // Store the new point, retire the old one, slide the window
            ST_WRITE: begin
                cur_we     = 1'b1;
                cur_wdata  = endpoint ? '0 : sat_val;
                prev_we    = 1'b1;
                prev_wdata = r_w_cur;
                if (!endpoint && (clip_hi || clip_lo)) begin
                    n_sat = 1'b1;
                end
                n_w_left = r_w_cur;
                n_w_cur  = r_w_next;
                n_addr   = r_addr + AW'(1);
                if (r_pt == PW'(POINT_COUNT - 1)) begin
                    n_pt    = '0;
                    n_state = last_cell ? ST_EMIT : ST_PRIME;
                end else begin
                    n_pt       = r_pt + PW'(1);
                    cur_raddr  = read_ahead ? (r_addr + AW'(2)) : r_addr;
                    prev_raddr = r_addr + AW'(1);
                    n_state    = ST_LOAD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_comb begin
        n_wave_speed = r_wave_speed;
        n_damping    = r_damping;
        n_time_step  = r_time_step;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_SPEED: n_wave_speed = i_cfg_data;
                CFG_DAMPING:    n_damping    = i_cfg_data;
                CFG_TIME_STEP:  n_time_step  = i_cfg_data;
                default: begin
                    n_wave_speed = r_wave_speed;
                end
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_pt         <= '0;
            r_is_read    <= 1'b0;
            r_sat        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wave_speed <= WAVE_SPEED_RST;
            r_damping    <= DAMPING_RST;
            r_time_step  <= TIME_STEP_RST;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_pt         <= n_pt;
            r_is_read    <= n_is_read;
            r_sat        <= n_sat;
            r_out_valid  <= n_out_valid;
            r_wave_speed <= n_wave_speed;
            r_damping    <= n_damping;
            r_time_step  <= n_time_step;
        end
    end

    // Datapath and result payload registers
    always_ff @(posedge i_clk) begin
        r_cfl        <= n_cfl;
        r_gd         <= n_gd;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_lap        <= n_lap;
        r_vel        <= n_vel;
        r_w_left     <= n_w_left;
        r_w_cur      <= n_w_cur;
        r_w_next     <= n_w_next;
        r_read_value <= n_read_value;
        r_saturated  <= n_saturated;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_saturated  = r_saturated;

    // One transaction in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("transaction accepted while another is in work");

    // Pinned ends always store zero
    a_endpoint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && endpoint) |-> (cur_we && cur_wdata == '0))
        else $error("endpoint written with nonzero displacement");

    // A saturation flag never travels with read data
    a_flag_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_read_value == '0))
        else $error("saturation flag with nonzero read value");

    // Point counter stays within a string
    a_pt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (32'(r_pt) < POINT_COUNT))
        else $error("point counter beyond string length");

endmodule
